@@ hw/rtl/vss_pkg.sv @@
// Shared types and constants of the valve step sequencer.
// Holds item structs, request, event, phase and register codes.
// No dependencies.
`default_nettype none

package vss_pkg;

    localparam int MAX_STEPS = 16;
    localparam int IDX_W     = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int CNT_W     = IDX_W + 1;
    localparam int LEAD_W    = 22;
    localparam int STEPS_W   = 5;
    localparam int NODE_W    = 8;
    localparam int DUR_W     = 32;
    localparam int STEP_W    = 4;
    localparam int CFG_W     = 22;
    localparam int CFG_IDX_W = 1;

    localparam logic [LEAD_W-1:0] LEAD_MAX = '1;
    localparam logic [DUR_W-1:0]  DUR_MAX  = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PUMP_LEAD    = 1'b0,
        CFG_STEPS_IN_USE = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_REPLY = 2'd1,
        REQ_LOAD  = 2'd2,
        REQ_STOP  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        EV_STARTED  = 3'd0,
        EV_MOVED    = 3'd1,
        EV_NO_NEXT  = 3'd2,
        EV_STOPPED  = 3'd3,
        EV_NO_START = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_START_OPEN  = 3'd1,
        PH_START_CLOSE = 3'd2,
        PH_LEAD        = 3'd3,
        PH_RUN         = 3'd4,
        PH_ADV_OPEN    = 3'd5,
        PH_ADV_CLOSE   = 3'd6
    } t_phase;

    typedef struct packed {
        logic [1:0]        req_type;
        logic              acked;
        logic [STEP_W-1:0] entry_index;
        logic [NODE_W-1:0] entry_node;
        logic [DUR_W-1:0]  entry_duration;
    } t_in_item;

    typedef struct packed {
        logic              cmd_valid;
        logic              cmd_open;
        logic [NODE_W-1:0] cmd_node;
        logic [STEP_W-1:0] cmd_step;
        logic [DUR_W-1:0]  cmd_duration;
        logic              pump_drive;
        logic              event_valid;
        logic [2:0]        event_code;
        logic [STEP_W-1:0] active_step;
        logic              active_valid;
        logic              busy_res;
    } t_out_item;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [NODE_W-1:0] node;
        logic [DUR_W-1:0]  dur;
    } t_tbl_wr;

endpackage

`default_nettype wire

@@ hw/rtl/vss_in_reg.sv @@
// Input register of the valve step sequencer: holds one accepted item.
// Depends on vss_pkg.
`default_nettype none

module vss_in_reg (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  vss_pkg::t_in_item i_item,
    output logic             o_valid,
    input  wire              i_take,
    output vss_pkg::t_in_item o_item
);

    logic              r_valid;
    vss_pkg::t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/vss_table.sv @@
// Step table: node number and duration per entry, one write and one read port.
// Depends on vss_pkg.
`default_nettype none

module vss_table (
    input  wire                            i_clk,
    input  vss_pkg::t_tbl_wr               i_wr,
    input  wire  [vss_pkg::IDX_W-1:0]      i_rd_idx,
    output logic [vss_pkg::NODE_W-1:0]     o_rd_node,
    output logic [vss_pkg::DUR_W-1:0]      o_rd_dur
);

    logic [vss_pkg::NODE_W-1:0] r_node [vss_pkg::MAX_STEPS];
    logic [vss_pkg::DUR_W-1:0]  r_dur  [vss_pkg::MAX_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_node[i_wr.idx] <= i_wr.node;
            r_dur[i_wr.idx]  <= i_wr.dur;
        end
    end

    assign o_rd_node = r_node[i_rd_idx];
    assign o_rd_dur  = r_dur[i_rd_idx];

endmodule

`default_nettype wire

@@ hw/rtl/vss_ctrl.sv @@
// Sequencer control: phase machine, step timing and result build per item.
// Depends on vss_pkg; reads the step table through its read port, which the top connects to vss_table.
`default_nettype none

module vss_ctrl (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_go,
    input  vss_pkg::t_in_item            i_item,
    input  wire  [vss_pkg::LEAD_W-1:0]   i_pump_lead,
    input  wire  [vss_pkg::STEPS_W-1:0]  i_steps_in_use,
    output logic [vss_pkg::IDX_W-1:0]    o_rd_idx,
    input  wire  [vss_pkg::NODE_W-1:0]   i_rd_node,
    input  wire  [vss_pkg::DUR_W-1:0]    i_rd_dur,
    output vss_pkg::t_tbl_wr             o_wr,
    output vss_pkg::t_out_item           o_res
);

    localparam int IDX_W = vss_pkg::IDX_W;
    localparam int CNT_W = vss_pkg::CNT_W;

    vss_pkg::t_phase            r_phase, n_phase;
    logic                       r_loaded, n_loaded;
    logic [IDX_W-1:0]           r_scan, n_scan;
    logic [IDX_W-1:0]           r_cur, n_cur;
    logic                       r_cur_v, n_cur_v;
    logic [IDX_W-1:0]           r_found, n_found;
    logic                       r_found_v, n_found_v;
    logic [vss_pkg::DUR_W-1:0]  r_elapsed, n_elapsed;
    logic [vss_pkg::LEAD_W-1:0] r_lead, n_lead;
    logic                       r_pump, n_pump;
    logic [vss_pkg::DUR_W-1:0]  r_cur_dur, n_cur_dur;

    logic [CNT_W-1:0] steps_n;
    logic             load_ok;

    always_comb begin
        if (int'(i_steps_in_use) > vss_pkg::MAX_STEPS) begin
            steps_n = CNT_W'(vss_pkg::MAX_STEPS);
        end else begin
            steps_n = CNT_W'(i_steps_in_use);
        end
    end

    assign load_ok  = int'(i_item.entry_index) < vss_pkg::MAX_STEPS;
    assign o_wr.en  = i_go && (vss_pkg::t_req'(i_item.req_type) == vss_pkg::REQ_LOAD) && load_ok;
    assign o_wr.idx  = IDX_W'(i_item.entry_index);
    assign o_wr.node = i_item.entry_node;
    assign o_wr.dur  = i_item.entry_duration;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= vss_pkg::PH_IDLE;
            r_loaded  <= 1'b0;
            r_scan    <= '0;
            r_cur     <= '0;
            r_cur_v   <= 1'b0;
            r_found   <= '0;
            r_found_v <= 1'b0;
            r_elapsed <= '0;
            r_lead    <= '0;
            r_pump    <= 1'b0;
            r_cur_dur <= '0;
        end else if (i_go) begin
            r_phase   <= n_phase;
            r_loaded  <= n_loaded;
            r_scan    <= n_scan;
            r_cur     <= n_cur;
            r_cur_v   <= n_cur_v;
            r_found   <= n_found;
            r_found_v <= n_found_v;
            r_elapsed <= n_elapsed;
            r_lead    <= n_lead;
            r_pump    <= n_pump;
            r_cur_dur <= n_cur_dur;
        end
    end

    always_comb begin
        logic             cmd_v;
        logic             cmd_open;
        logic [IDX_W-1:0] cmd_idx;
        logic             ev_v;
        vss_pkg::t_event  ev_code;
        logic             do_sweep;
        logic             do_begin;
        logic             rd_found;
        logic [CNT_W-1:0] sweep_from;
        logic [CNT_W-1:0] sweep_i;
        logic [CNT_W-1:0] scan_inc;
        logic [CNT_W-1:0] cur_inc;

        n_phase   = r_phase;
        n_loaded  = r_loaded;
        n_scan    = r_scan;
        n_cur     = r_cur;
        n_cur_v   = r_cur_v;
        n_found   = r_found;
        n_found_v = r_found_v;
        n_elapsed = r_elapsed;
        n_lead    = r_lead;
        n_pump    = r_pump;
        n_cur_dur = r_cur_dur;
        cmd_v     = 1'b0;
        cmd_open  = 1'b0;
        cmd_idx   = '0;
        ev_v      = 1'b0;
        ev_code   = vss_pkg::EV_STARTED;
        do_sweep  = 1'b0;
        do_begin  = 1'b0;
        rd_found  = 1'b0;
        sweep_from = '0;
        sweep_i   = '0;
        scan_inc  = {1'b0, r_scan} + CNT_W'(1);
        cur_inc   = {1'b0, r_cur} + CNT_W'(1);

        unique case (vss_pkg::t_req'(i_item.req_type))
            vss_pkg::REQ_LOAD: begin
                if (load_ok) begin
                    n_loaded = 1'b1;
                    if (IDX_W'(i_item.entry_index) == r_cur) begin
                        n_cur_dur = i_item.entry_duration;
                    end
                end
            end
            vss_pkg::REQ_STOP: begin
                if (r_cur_v && ({1'b0, r_cur} < steps_n)) begin
                    cmd_v   = 1'b1;
                    cmd_idx = r_cur;
                end
                n_pump    = 1'b0;
                n_phase   = vss_pkg::PH_IDLE;
                n_cur_v   = 1'b0;
                n_found_v = 1'b0;
                ev_v      = 1'b1;
                ev_code   = vss_pkg::EV_STOPPED;
            end
            vss_pkg::REQ_TICK: begin
                unique case (r_phase)
                    vss_pkg::PH_IDLE: begin
                        if (r_loaded && (steps_n != '0)) begin
                            n_scan    = '0;
                            n_found_v = 1'b0;
                            n_phase   = vss_pkg::PH_START_OPEN;
                            cmd_v     = 1'b1;
                            cmd_open  = 1'b1;
                            cmd_idx   = '0;
                        end
                    end
                    vss_pkg::PH_LEAD: begin
                        if (r_lead != vss_pkg::LEAD_MAX) begin
                            n_lead = r_lead + vss_pkg::LEAD_W'(1);
                        end
                        if (n_lead >= i_pump_lead) begin
                            do_begin = 1'b1;
                        end
                    end
                    vss_pkg::PH_RUN: begin
                        if (!r_cur_v || ({1'b0, r_cur} >= steps_n)) begin
                            n_pump    = 1'b0;
                            n_phase   = vss_pkg::PH_IDLE;
                            n_cur_v   = 1'b0;
                            n_found_v = 1'b0;
                            ev_v      = 1'b1;
                            ev_code   = vss_pkg::EV_NO_NEXT;
                        end else begin
                            if (r_elapsed != vss_pkg::DUR_MAX) begin
                                n_elapsed = r_elapsed + vss_pkg::DUR_W'(1);
                            end
                            if (n_elapsed >= r_cur_dur) begin
                                n_found_v = 1'b0;
                                n_scan    = cur_inc[IDX_W-1:0];
                                cmd_v     = 1'b1;
                                if (cur_inc < steps_n) begin
                                    n_phase  = vss_pkg::PH_ADV_OPEN;
                                    cmd_open = 1'b1;
                                    cmd_idx  = cur_inc[IDX_W-1:0];
                                end else begin
                                    n_phase = vss_pkg::PH_ADV_CLOSE;
                                    cmd_idx = r_cur;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            vss_pkg::REQ_REPLY: begin
                unique case (r_phase)
                    vss_pkg::PH_START_OPEN: begin
                        if (i_item.acked) begin
                            n_found    = r_scan;
                            n_found_v  = 1'b1;
                            do_sweep   = 1'b1;
                            sweep_from = '0;
                        end else begin
                            n_scan = scan_inc[IDX_W-1:0];
                            if (scan_inc < steps_n) begin
                                cmd_v    = 1'b1;
                                cmd_open = 1'b1;
                                cmd_idx  = scan_inc[IDX_W-1:0];
                            end else begin
                                n_phase = vss_pkg::PH_IDLE;
                                ev_v    = 1'b1;
                                ev_code = vss_pkg::EV_NO_START;
                            end
                        end
                    end
                    vss_pkg::PH_START_CLOSE: begin
                        do_sweep   = 1'b1;
                        sweep_from = scan_inc;
                    end
                    vss_pkg::PH_ADV_OPEN: begin
                        cmd_v = 1'b1;
                        if (i_item.acked) begin
                            n_found   = r_scan;
                            n_found_v = 1'b1;
                            n_phase   = vss_pkg::PH_ADV_CLOSE;
                            cmd_idx   = r_cur;
                        end else begin
                            n_scan = scan_inc[IDX_W-1:0];
                            if (scan_inc < steps_n) begin
                                cmd_open = 1'b1;
                                cmd_idx  = scan_inc[IDX_W-1:0];
                            end else begin
                                n_phase = vss_pkg::PH_ADV_CLOSE;
                                cmd_idx = r_cur;
                            end
                        end
                    end
                    vss_pkg::PH_ADV_CLOSE: begin
                        if (r_found_v) begin
                            n_cur     = r_found;
                            n_cur_v   = 1'b1;
                            n_found_v = 1'b0;
                            n_elapsed = '0;
                            n_phase   = vss_pkg::PH_RUN;
                            n_cur_dur = i_rd_dur;
                            rd_found  = 1'b1;
                            ev_v      = 1'b1;
                            ev_code   = vss_pkg::EV_MOVED;
                        end else begin
                            n_pump    = 1'b0;
                            n_phase   = vss_pkg::PH_IDLE;
                            n_cur_v   = 1'b0;
                            n_found_v = 1'b0;
                            ev_v      = 1'b1;
                            ev_code   = vss_pkg::EV_NO_NEXT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        if (do_sweep) begin
            if ((sweep_from == {1'b0, n_found}) && (sweep_from < steps_n)) begin
                sweep_i = sweep_from + CNT_W'(1);
            end else begin
                sweep_i = sweep_from;
            end
            if (sweep_i < steps_n) begin
                n_scan  = sweep_i[IDX_W-1:0];
                n_phase = vss_pkg::PH_START_CLOSE;
                cmd_v   = 1'b1;
                cmd_idx = sweep_i[IDX_W-1:0];
            end else begin
                n_pump = 1'b1;
                n_lead = '0;
                if (i_pump_lead == '0) begin
                    do_begin = 1'b1;
                end else begin
                    n_phase = vss_pkg::PH_LEAD;
                end
            end
        end

        if (do_begin) begin
            n_phase   = vss_pkg::PH_RUN;
            n_cur     = n_found;
            n_cur_v   = 1'b1;
            n_found_v = 1'b0;
            n_elapsed = '0;
            n_cur_dur = i_rd_dur;
            rd_found  = 1'b1;
            ev_v      = 1'b1;
            ev_code   = vss_pkg::EV_STARTED;
        end

        o_rd_idx = rd_found ? n_found : cmd_idx;

        o_res.cmd_valid    = cmd_v;
        o_res.cmd_open     = cmd_v && cmd_open;
        o_res.cmd_node     = cmd_v ? i_rd_node : '0;
        o_res.cmd_step     = cmd_v ? vss_pkg::STEP_W'(cmd_idx) : '0;
        o_res.cmd_duration = (cmd_v && cmd_open) ? i_rd_dur : '0;
        o_res.pump_drive   = n_pump;
        o_res.event_valid  = ev_v;
        o_res.event_code   = ev_v ? ev_code : vss_pkg::EV_STARTED;
        o_res.active_step  = n_cur_v ? vss_pkg::STEP_W'(n_cur) : '0;
        o_res.active_valid = n_cur_v;
        o_res.busy_res     = (n_phase != vss_pkg::PH_IDLE) && (n_phase != vss_pkg::PH_RUN);
    end

endmodule

`default_nettype wire

@@ hw/rtl/vss_out_reg.sv @@
// Result register of the valve step sequencer: holds one item until taken.
// Depends on vss_pkg.
`default_nettype none

module vss_out_reg (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_load,
    output logic              o_room,
    input  vss_pkg::t_out_item i_res,
    output logic              o_valid,
    input  wire               i_ready,
    output vss_pkg::t_out_item o_item
);

    logic               r_valid;
    vss_pkg::t_out_item r_item;

    assign o_room  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_res;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/valve_step_sequencer_unit.sv @@
// Top level of the valve step sequencer: input register, control, step table,
// result register and the configuration registers. Depends on vss_pkg.
//
//   channel   direction  handshake              payload
//   input     in         i_valid / o_ready      i_item  (vss_pkg::t_in_item)
//   result    out        o_valid / i_ready      o_item  (vss_pkg::t_out_item)
//   config    in         i_cfg_wen (no wait)    i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while the result channel is ready; each item passes
// the input register, then the single-pass step logic, and its result is held in
// the result register. Exactly one result per item, in order.
// Synchronous reset clears control and sequencer state; table entries are
// undefined until loaded. A stalled result holds in the result register while
// the input register still takes one more item.
`default_nettype none

module valve_step_sequencer_unit (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    output logic                              o_ready,
    input  vss_pkg::t_in_item                 i_item,
    output logic                              o_valid,
    input  wire                               i_ready,
    output vss_pkg::t_out_item                o_item,
    input  wire                               i_cfg_wen,
    input  wire  [vss_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [vss_pkg::CFG_W-1:0]         i_cfg_data
);

    logic [vss_pkg::LEAD_W-1:0]  r_pump_lead;
    logic [vss_pkg::STEPS_W-1:0] r_steps_in_use;

    logic                        in_valid;
    vss_pkg::t_in_item           in_item;
    logic                        out_room;
    logic                        go;
    logic [vss_pkg::IDX_W-1:0]   rd_idx;
    logic [vss_pkg::NODE_W-1:0]  rd_node;
    logic [vss_pkg::DUR_W-1:0]   rd_dur;
    vss_pkg::t_tbl_wr            tbl_wr;
    vss_pkg::t_out_item          res;

    assign go = in_valid && out_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pump_lead    <= '0;
            r_steps_in_use <= '0;
        end else if (i_cfg_wen) begin
            unique case (vss_pkg::t_cfg_reg'(i_cfg_idx))
                vss_pkg::CFG_PUMP_LEAD:    r_pump_lead    <= i_cfg_data[vss_pkg::LEAD_W-1:0];
                vss_pkg::CFG_STEPS_IN_USE: r_steps_in_use <= i_cfg_data[vss_pkg::STEPS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    vss_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (in_valid),
        .i_take  (out_room),
        .o_item  (in_item)
    );

    vss_table u_table (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd_idx  (rd_idx),
        .o_rd_node (rd_node),
        .o_rd_dur  (rd_dur)
    );

    vss_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (go),
        .i_item         (in_item),
        .i_pump_lead    (r_pump_lead),
        .i_steps_in_use (r_steps_in_use),
        .o_rd_idx       (rd_idx),
        .i_rd_node      (rd_node),
        .i_rd_dur       (rd_dur),
        .o_wr           (tbl_wr),
        .o_res          (res)
    );

    vss_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (go),
        .o_room  (out_room),
        .i_res   (res),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

endmodule

`default_nettype wire

@@ hw/rtl/vss_checker.sv @@
// Port-level checks of the valve step sequencer and their bind to the top.
// Depends on vss_pkg and valve_step_sequencer_unit.
`default_nettype none

module vss_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                o_valid,
    input wire                i_ready,
    input vss_pkg::t_out_item o_item
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("stalled result item changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_no_cmd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.cmd_valid |->
            !o_item.cmd_open && o_item.cmd_node == '0 &&
            o_item.cmd_step == '0 && o_item.cmd_duration == '0)
        else $error("command fields set without a command");

    a_close_no_dur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.cmd_valid && !o_item.cmd_open |-> o_item.cmd_duration == '0)
        else $error("close command carries a duration");

    a_stop_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.event_valid && o_item.event_code == vss_pkg::EV_STOPPED |->
            !o_item.pump_drive && !o_item.active_valid && !o_item.busy_res)
        else $error("stop left pump, step or wait active");

endmodule

bind valve_step_sequencer_unit vss_checker u_vss_checker (.*);

`default_nettype wire

@@ tb/sv/valve_step_sequencer_unit_tb.sv @@
// Self-checking testbench for valve_step_sequencer_unit: a directed table, then random
// sequences under random valid/ready gaps; results checked against a local model or
// the wants of the directed table. Depends on vss_pkg and the RTL only.
module valve_step_sequencer_unit_tb;
    import vss_pkg::*;

    localparam int CYCLE_LIMIT = 500_000;
    localparam int ITEM_TARGET = 930;
    localparam t_out_item NO_RESPONSE = '0;

    typedef struct {
        bit             set_cfg;
        logic [21:0]    lead;
        logic [4:0]     steps;
        t_in_item       item;
        bit             typed;
        t_out_item      want;
    } plan_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    t_in_item             i_item;
    logic                 o_valid;
    logic                 i_ready;
    t_out_item            o_item;
    logic                 i_cfg_wen;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    valve_step_sequencer_unit i_dut (.*);

    // sequencer model state
    logic [7:0]  tbl_node [MAX_STEPS];
    logic [31:0] tbl_dur [MAX_STEPS];
    bit          tbl_loaded = 1'b0;
    t_phase      ph = PH_IDLE;
    int          scan = 0;
    int          cur = 0;
    bit          cur_v = 1'b0;
    int          fnd = 0;
    bit          fnd_v = 1'b0;
    logic [31:0] elapsed = '0;
    logic [21:0] lead_cnt = '0;
    bit          pump_on = 1'b0;
    logic [21:0] lead_cfg = '0;
    logic [4:0]  steps_cfg = '0;
    t_out_item   pred;
    bit          pred_acted;

    t_out_item   pending_responses [$];
    plan_row_t   plan [$];
    int          errors = 0;
    int          results_seen = 0;
    int          effective_items = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic issue(input bit open, input int idx);
        pred.cmd_valid    = 1'b1;
        pred.cmd_open     = open;
        pred.cmd_node     = tbl_node[idx];
        pred.cmd_step     = 4'(idx);
        pred.cmd_duration = open ? tbl_dur[idx] : '0;
    endtask

    task automatic post(input t_event code);
        pred.event_valid = 1'b1;
        pred.event_code  = code;
    endtask

    task automatic begin_timing();
        ph      = PH_RUN;
        cur     = fnd;
        cur_v   = 1'b1;
        fnd_v   = 1'b0;
        elapsed = '0;
        post(EV_STARTED);
    endtask

    task automatic close_sweep(input int from, input int n);
        int i;
        i = from;
        while (i < n && fnd_v && i == fnd)
            i++;
        if (i < n) begin
            scan = i;
            ph   = PH_START_CLOSE;
            issue(1'b0, i);
        end else begin
            pump_on  = 1'b1;
            lead_cnt = '0;
            if (lead_cfg == '0) begin
                begin_timing();
            end else begin
                ph = PH_LEAD;
            end
        end
    endtask

    task automatic go_idle(input t_event code);
        pump_on = 1'b0;
        ph      = PH_IDLE;
        cur_v   = 1'b0;
        fnd_v   = 1'b0;
        post(code);
    endtask

    task automatic predict_seq_response(input t_in_item it, output t_out_item r);
        int n;
        n = (steps_cfg > MAX_STEPS) ? MAX_STEPS : int'(steps_cfg);
        pred = '0;
        pred_acted = 1'b1;
        case (it.req_type)
            REQ_LOAD: begin
                tbl_node[it.entry_index] = it.entry_node;
                tbl_dur[it.entry_index]  = it.entry_duration;
                tbl_loaded = 1'b1;
            end
            REQ_STOP: begin
                if (cur_v && cur < n)
                    issue(1'b0, cur);
                go_idle(EV_STOPPED);
            end
            REQ_TICK: begin
                case (ph)
                    PH_IDLE: begin
                        if (tbl_loaded && n > 0) begin
                            scan  = 0;
                            fnd_v = 1'b0;
                            ph    = PH_START_OPEN;
                            issue(1'b1, 0);
                        end else begin
                            pred_acted = 1'b0;
                        end
                    end
                    PH_LEAD: begin
                        if (lead_cnt != LEAD_MAX)
                            lead_cnt++;
                        if (lead_cnt >= lead_cfg)
                            begin_timing();
                    end
                    PH_RUN: begin
                        if (!cur_v || cur >= n) begin
                            go_idle(EV_NO_NEXT);
                        end else begin
                            if (elapsed != DUR_MAX)
                                elapsed++;
                            if (elapsed >= tbl_dur[cur]) begin
                                fnd_v = 1'b0;
                                scan  = cur + 1;
                                if (scan < n) begin
                                    ph = PH_ADV_OPEN;
                                    issue(1'b1, scan);
                                end else begin
                                    ph = PH_ADV_CLOSE;
                                    issue(1'b0, cur);
                                end
                            end
                        end
                    end
                    default: pred_acted = 1'b0;
                endcase
            end
            default: begin
                case (ph)
                    PH_START_OPEN: begin
                        if (it.acked) begin
                            fnd   = scan;
                            fnd_v = 1'b1;
                            close_sweep(0, n);
                        end else begin
                            scan++;
                            if (scan < n) begin
                                issue(1'b1, scan);
                            end else begin
                                ph = PH_IDLE;
                                post(EV_NO_START);
                            end
                        end
                    end
                    PH_START_CLOSE: close_sweep(scan + 1, n);
                    PH_ADV_OPEN: begin
                        if (it.acked) begin
                            fnd   = scan;
                            fnd_v = 1'b1;
                            ph    = PH_ADV_CLOSE;
                            issue(1'b0, cur);
                        end else begin
                            scan++;
                            if (scan < n) begin
                                issue(1'b1, scan);
                            end else begin
                                ph = PH_ADV_CLOSE;
                                issue(1'b0, cur);
                            end
                        end
                    end
                    PH_ADV_CLOSE: begin
                        if (fnd_v) begin
                            cur     = fnd;
                            cur_v   = 1'b1;
                            fnd_v   = 1'b0;
                            elapsed = '0;
                            ph      = PH_RUN;
                            post(EV_MOVED);
                        end else begin
                            go_idle(EV_NO_NEXT);
                        end
                    end
                    default: pred_acted = 1'b0;
                endcase
            end
        endcase
        pred.pump_drive   = pump_on;
        pred.active_valid = cur_v;
        pred.active_step  = cur_v ? 4'(cur) : '0;
        pred.busy_res     = (ph != PH_IDLE && ph != PH_RUN);
        r = pred;
    endtask

    function automatic t_in_item mk_req(input t_req kind, input bit ack = 1'b0,
                                        input int idx = 0, input int node = 0,
                                        input logic [31:0] dur = '0);
        t_in_item it;
        it = '0;
        it.req_type       = kind;
        it.acked          = ack;
        it.entry_index    = 4'(idx);
        it.entry_node     = 8'(node);
        it.entry_duration = dur;
        return it;
    endfunction

    function automatic t_out_item status_only(input t_event code);
        t_out_item o;
        o = '0;
        o.event_valid = 1'b1;
        o.event_code  = code;
        return o;
    endfunction

    task automatic plan_cfg(input logic [21:0] lead, input logic [4:0] steps);
        plan_row_t row;
        row = '{set_cfg: 1'b1, lead: lead, steps: steps, item: '0, typed: 1'b0, want: '0};
        plan.push_back(row);
    endtask

    task automatic plan_known(input t_in_item it, input t_out_item want);
        plan_row_t row;
        row = '{set_cfg: 1'b0, lead: '0, steps: '0, item: it, typed: 1'b1, want: want};
        plan.push_back(row);
    endtask

    task automatic plan_item(input t_in_item it);
        plan_row_t row;
        row = '{set_cfg: 1'b0, lead: '0, steps: '0, item: it, typed: 1'b0, want: '0};
        plan.push_back(row);
    endtask

    function automatic int idle_gap();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_dur();
        int r;
        r = $urandom_range(99);
        if (r < 85)
            return 32'($urandom_range(4));
        if (r < 95)
            return 32'($urandom_range(5, 40));
        return $urandom;
    endfunction

    function automatic logic [21:0] pick_lead();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return '0;
        if (r < 75)
            return 22'($urandom_range(1, 4));
        if (r < 88)
            return 22'($urandom_range(5, 30));
        if (r < 94)
            return 22'($urandom);
        return LEAD_MAX;
    endfunction

    function automatic logic [4:0] pick_steps();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 70)
            return 5'($urandom_range(1, 5));
        if (r < 85)
            return 5'($urandom_range(6, 16));
        if (r < 92)
            return 5'(MAX_STEPS);
        return 5'($urandom_range(17, 31));
    endfunction

    function automatic t_in_item pick_item();
        t_in_item it;
        int r;
        it.req_type       = 2'($urandom);
        it.acked          = 1'($urandom);
        it.entry_index    = 4'($urandom);
        it.entry_node     = 8'($urandom);
        it.entry_duration = $urandom;
        r = $urandom_range(99);
        if (r < 3) begin
            it.req_type = REQ_STOP;
        end else if (r < 11) begin
            it.req_type       = REQ_LOAD;
            it.entry_duration = pick_dur();
        end else if (r < 19) begin
            // keep as noise
        end else if (ph inside {PH_START_OPEN, PH_START_CLOSE, PH_ADV_OPEN, PH_ADV_CLOSE}) begin
            it.req_type = REQ_REPLY;
            it.acked    = ($urandom_range(99) < 40);
        end else begin
            it.req_type = REQ_TICK;
        end
        return it;
    endfunction

    task automatic offer(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item r;
        predict_seq_response(it, r);
        pending_responses.push_back(typed ? want : r);
        if (pred_acted)
            effective_items++;
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [21:0] lead, input logic [4:0] steps,
                                  input logic [16:0] pad);
        i_cfg_wen  <= 1'b1;
        i_cfg_idx  <= CFG_PUMP_LEAD;
        i_cfg_data <= lead;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_STEPS_IN_USE;
        i_cfg_data <= {pad, steps};
        @(posedge i_clk);
        i_cfg_wen  <= 1'b0;
        lead_cfg  = lead;
        steps_cfg = steps;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_responses.size() == 0) begin
                errors++;
                $display("%0t: unexpected item, expected none got %h", $time, o_item);
            end else begin
                want = pending_responses.pop_front();
                check_field("cmd_valid", want.cmd_valid, o_item.cmd_valid);
                check_field("cmd_open", want.cmd_open, o_item.cmd_open);
                check_field("cmd_node", want.cmd_node, o_item.cmd_node);
                check_field("cmd_step", want.cmd_step, o_item.cmd_step);
                check_field("cmd_duration", want.cmd_duration, o_item.cmd_duration);
                check_field("pump_drive", want.pump_drive, o_item.pump_drive);
                check_field("event_valid", want.event_valid, o_item.event_valid);
                check_field("event_code", want.event_code, o_item.event_code);
                check_field("active_step", want.active_step, o_item.active_step);
                check_field("active_valid", want.active_valid, o_item.active_valid);
                check_field("busy_res", want.busy_res, o_item.busy_res);
            end
        end
    end

    initial begin : result_sink
        int gap;
        bit held_long;
        held_long = 1'b0;
        i_ready <= 1'b0;
        forever begin
            if (!held_long && results_seen >= 300) begin
                held_long = 1'b1;
                i_ready <= 1'b0;
                repeat (80) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
            gap = idle_gap();
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("valve_step_sequencer_unit test failed");
        $finish;
    end

    initial begin : stimulus
        int seg;
        int len;
        bit no_gaps;

        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_item     <= '0;
        i_cfg_wen  <= 1'b0;
        i_cfg_idx  <= CFG_PUMP_LEAD;
        i_cfg_data <= '0;

        plan_cfg('0, '0);
        plan_known(mk_req(REQ_TICK), NO_RESPONSE);
        plan_known(mk_req(REQ_REPLY, 1'b1), NO_RESPONSE);
        plan_known(mk_req(REQ_STOP), status_only(EV_STOPPED));
        plan_known(mk_req(REQ_LOAD, 1'b0, 0, 255, 32'h0), NO_RESPONSE);
        plan_known(mk_req(REQ_LOAD, 1'b1, 1, 0, 32'hFFFF_FFFF), NO_RESPONSE);
        plan_known(mk_req(REQ_LOAD, 1'b0, 2, 8'h5A, 32'd1), NO_RESPONSE);
        plan_known(mk_req(REQ_LOAD, 1'b0, 15, 8'hA5, 32'h1234), NO_RESPONSE);
        plan_known(mk_req(REQ_TICK), NO_RESPONSE);
        plan_cfg('0, 5'd3);
        plan_item(mk_req(REQ_TICK));
        plan_item(mk_req(REQ_REPLY));
        plan_item(mk_req(REQ_REPLY));
        plan_known(mk_req(REQ_REPLY), status_only(EV_NO_START));
        plan_item(mk_req(REQ_TICK));
        plan_item(mk_req(REQ_TICK));
        plan_item(mk_req(REQ_REPLY, 1'b1));
        plan_item(mk_req(REQ_REPLY));
        plan_item(mk_req(REQ_REPLY));
        plan_item(mk_req(REQ_TICK));
        plan_item(mk_req(REQ_REPLY));
        plan_item(mk_req(REQ_REPLY, 1'b1));
        plan_item(mk_req(REQ_REPLY));
        plan_item(mk_req(REQ_TICK));
        plan_item(mk_req(REQ_REPLY));
        plan_cfg(22'd2, 5'd2);
        plan_item(mk_req(REQ_TICK));
        plan_item(mk_req(REQ_REPLY, 1'b1));
        plan_item(mk_req(REQ_REPLY));
        plan_item(mk_req(REQ_TICK));
        plan_item(mk_req(REQ_TICK));
        plan_item(mk_req(REQ_STOP));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].set_cfg) begin
                settle();
                write_settings(plan[k].lead, plan[k].steps, '0);
            end else begin
                offer(plan[k].item, plan[k].typed, plan[k].want);
                pause(idle_gap());
            end
        end

        // fill the whole table before any random sequence can read it
        for (int e = 0; e < MAX_STEPS; e++) begin
            offer(mk_req(REQ_LOAD, 1'($urandom), e, $urandom_range(255), pick_dur()),
                  1'b0, NO_RESPONSE);
            pause(idle_gap());
        end

        seg = 0;
        while (effective_items < ITEM_TARGET) begin
            settle();
            case (seg)
                0: write_settings('0, 5'(MAX_STEPS), '1);
                1: write_settings(LEAD_MAX, 5'd31, 17'($urandom));
                2: write_settings(22'd3600000, 5'd17, '0);
                default: begin
                    if ($urandom_range(99) < 70)
                        write_settings(pick_lead(), pick_steps(), 17'($urandom));
                end
            endcase
            len     = $urandom_range(20, 120);
            no_gaps = ($urandom_range(99) < 20);
            repeat (len) begin
                offer(pick_item(), 1'b0, NO_RESPONSE);
                pause(no_gaps ? 0 : idle_gap());
            end
            seg++;
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("valve_step_sequencer_unit test passed");
        end else begin
            $display("valve_step_sequencer_unit test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/vss_pkg.sv
hw/rtl/vss_in_reg.sv
hw/rtl/vss_table.sv
hw/rtl/vss_ctrl.sv
hw/rtl/vss_out_reg.sv
hw/rtl/valve_step_sequencer_unit.sv
hw/rtl/vss_checker.sv
tb/sv/valve_step_sequencer_unit_tb.sv
